>>> hdl/pesw_pkg.sv
// pesw_pkg: widths, register indexes, reset values and the command and status
// structs shared by the edge walker's controller, datapath and top level.
// No dependencies.
`default_nettype none
package pesw_pkg;

   // field widths
   localparam int COORD_W    = 16;
   localparam int ROW_W      = 6;
   localparam int COL_W      = 10;
   localparam int ROWS_W     = 7;
   localparam int CNT_W      = 7;
   localparam int DY_W       = 16;
   localparam int GAIN_W     = 17;
   localparam int PROD_W     = 32;
   localparam int X_W        = 19;
   localparam int F_W        = 17;
   localparam int S_W        = 18;
   localparam int K_W        = 18;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_TILE_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TILE_COLS = 2'd1;

   // register reset values
   localparam logic [ROWS_W-1:0] TILE_ROWS_RST = 7'd32;
   localparam logic [COL_W-1:0]  TILE_COLS_RST = 10'd512;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic setup;
      logic mul;
      logic div_start;
      logic div_gain;
      logic take_jump;
      logic take_gain;
      logic emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic reject;
      logic neg_top;
      logic div_done;
      logic out_free;
      logic last_row;
   } status_type;

endpackage
`default_nettype wire

>>> hdl/pesw_divider.sv
// pesw_divider: restoring divider, one quotient bit per cycle, for the
// row jump and the per-row step split. Depends on pesw_pkg.
`default_nettype none
module pesw_divider
   import pesw_pkg::*;
(
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   input  wire [PROD_W-1:0]   dividend,
   input  wire [DY_W-1:0]     divisor,
   output logic               busy,
   output logic               done,
   output logic [PROD_W-1:0]  quotient,
   output logic [DY_W-1:0]    remainder
);

   localparam int DCNT_W = $clog2(PROD_W);

   logic [PROD_W-1:0] quo_ff, quo_in;
   logic [DY_W-1:0]   rem_ff, rem_in;
   logic [DY_W-1:0]   dvs_ff, dvs_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [DY_W:0] trial;
   logic [DY_W:0] diff;
   logic          ge;

   // trial subtraction of the divisor from the partial remainder
   assign trial = {rem_ff, quo_ff[PROD_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign ge    = (trial >= {1'b0, dvs_ff});

   // iteration control
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[PROD_W-2:0], ge};
         rem_in = ge ? diff[DY_W-1:0] : trial[DY_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DCNT_W'(PROD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

>>> hdl/pesw_ctrl.sv
// pesw_ctrl: sequencing state machine of the edge walker: setup, optional
// row jump, step split, row walk. Depends on pesw_pkg.
`default_nettype none
module pesw_ctrl
   import pesw_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  status_type  st,
   output cmd_type     cmd
);

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_SETUP     = 3'd1;
   localparam logic [2:0] ST_MUL       = 3'd2;
   localparam logic [2:0] ST_DIVJ_GO   = 3'd3;
   localparam logic [2:0] ST_DIVJ_WAIT = 3'd4;
   localparam logic [2:0] ST_DIVG_GO   = 3'd5;
   localparam logic [2:0] ST_DIVG_WAIT = 3'd6;
   localparam logic [2:0] ST_WALK      = 3'd7;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.load      = req_valid && (state_ff == ST_IDLE);
      cmd.setup     = (state_ff == ST_SETUP);
      cmd.mul       = (state_ff == ST_MUL);
      cmd.div_start = (state_ff == ST_DIVJ_GO) || (state_ff == ST_DIVG_GO);
      cmd.div_gain  = (state_ff == ST_DIVG_GO);
      cmd.take_jump = (state_ff == ST_DIVJ_WAIT) && st.div_done;
      cmd.take_gain = (state_ff == ST_DIVG_WAIT) && st.div_done;
      cmd.emit      = (state_ff == ST_WALK) && st.out_free;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SETUP;
         end
         ST_SETUP: begin
            if (st.reject)       state_in = ST_IDLE;
            else if (st.neg_top) state_in = ST_MUL;
            else                 state_in = ST_DIVG_GO;
         end
         ST_MUL:       state_in = ST_DIVJ_GO;
         ST_DIVJ_GO:   state_in = ST_DIVJ_WAIT;
         ST_DIVJ_WAIT: begin
            if (st.div_done) state_in = ST_DIVG_GO;
         end
         ST_DIVG_GO:   state_in = ST_DIVG_WAIT;
         ST_DIVG_WAIT: begin
            if (st.div_done) state_in = ST_WALK;
         end
         ST_WALK: begin
            if (st.out_free && st.last_row) state_in = ST_IDLE;
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   // a crossing is only handed over when the output slot can take it
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> st.out_free)
      else $error("crossing emitted into a full output slot");

   // a rejected edge returns straight to idle
   a_reject_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SETUP && st.reject) |=> state_ff == ST_IDLE)
      else $error("rejected edge did not return to idle");

   // the final crossing ends the walk
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && st.last_row) |=> (state_ff == ST_IDLE))
      else $error("walk continued past final crossing");
`endif

endmodule
`default_nettype wire

>>> hdl/pesw_datapath.sv
// pesw_datapath: endpoint ordering, edge setup, jump multiply, shared divider,
// error-accumulator row walk and the result register. Depends on pesw_pkg
// and pesw_divider.
`default_nettype none
module pesw_datapath
   import pesw_pkg::*;
#(
   parameter int MAX_ROWS = 64
)
(
   input  wire                       clock,
   input  wire                       reset,
   input  cmd_type                   cmd,
   output status_type                st,
   input  wire [ROWS_W-1:0]          tile_rows,
   input  wire [COL_W-1:0]           tile_cols,
   input  wire signed [COORD_W-1:0]  req_start_x,
   input  wire signed [COORD_W-1:0]  req_start_y,
   input  wire signed [COORD_W-1:0]  req_end_x,
   input  wire signed [COORD_W-1:0]  req_end_y,
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   output logic [ROW_W-1:0]          rsp_row,
   output logic [COL_W-1:0]          rsp_cross_x,
   output logic                      rsp_last
);

   // ordered endpoints
   logic signed [COORD_W-1:0] top_x_ff, top_x_in, top_y_ff, top_y_in;
   logic signed [COORD_W-1:0] bot_x_ff, bot_x_in, bot_y_ff, bot_y_in;
   // edge setup
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [DY_W-1:0]    dy_ff, dy_in;
   logic [GAIN_W-1:0]  gain_ff, gain_in;
   logic [COORD_W-1:0] neg_top_ff, neg_top_in;
   logic               step_pos_ff, step_pos_in, step_neg_ff, step_neg_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   // walker
   logic signed [X_W-1:0] x_ff, x_in;
   logic signed [F_W-1:0] f_ff, f_in;
   logic [GAIN_W-1:0]     q_ff, q_in;
   logic [DY_W-1:0]       r_ff, r_in;
   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0]   rsp_row_ff, rsp_row_in;
   logic [COL_W-1:0]   rsp_cross_x_ff, rsp_cross_x_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [ROWS_W-1:0]       limit;
   logic signed [COORD_W:0] limit_s, top_y_s, bot_y_s, top_x_s, bot_x_s;
   logic signed [COORD_W:0] dy_s, dx_s;
   logic [COORD_W:0]        dx_mag;
   logic [ROW_W-1:0]        y0;
   logic [ROWS_W-1:0]       lo;
   logic                    reject;

   logic signed [S_W-1:0]   s_w, dy_w18, f_next;
   logic [K_W-1:0]          k_w;
   logic signed [X_W-1:0]   k_x, jump_x, x_next, cols_x;
   logic [COL_W-1:0]        cx;

   logic [PROD_W-1:0] div_dividend, div_quo;
   logic [DY_W-1:0]   div_rem;
   logic              div_busy, div_done;

   // row limit saturates at the configured maximum
   assign limit = (tile_rows > ROWS_W'(MAX_ROWS)) ? ROWS_W'(MAX_ROWS) : tile_rows;

   // setup arithmetic on the ordered endpoints
   assign limit_s = $signed({{(COORD_W + 1 - ROWS_W){1'b0}}, limit});
   assign top_y_s = {top_y_ff[COORD_W-1], top_y_ff};
   assign bot_y_s = {bot_y_ff[COORD_W-1], bot_y_ff};
   assign top_x_s = {top_x_ff[COORD_W-1], top_x_ff};
   assign bot_x_s = {bot_x_ff[COORD_W-1], bot_x_ff};
   assign dy_s    = bot_y_s - top_y_s;
   assign dx_s    = bot_x_s - top_x_s;
   assign dx_mag  = dx_s[COORD_W] ? (~dx_s + 1'b1) : dx_s;
   assign reject  = (bot_y_s <= $signed((COORD_W + 1)'(0))) || (top_y_s >= limit_s)
                    || (top_y_ff == bot_y_ff) || (limit == '0);
   assign y0      = top_y_ff[COORD_W-1] ? '0 : top_y_ff[ROW_W-1:0];
   assign lo      = (bot_y_s < limit_s) ? bot_y_ff[ROWS_W-1:0] : limit;

   // per-row step split: err gains q*dy + r, folded with one correction
   assign dy_w18 = $signed({{(S_W - DY_W){1'b0}}, dy_ff});
   assign s_w    = $signed({f_ff[F_W-1], f_ff}) + $signed({{(S_W - DY_W){1'b0}}, r_ff});
   always_comb begin
      if (s_w < $signed(S_W'(0))) begin
         k_w    = {1'b0, q_ff} - 1'b1;
         f_next = s_w + dy_w18;
      end else if (s_w >= dy_w18) begin
         k_w    = {1'b0, q_ff} + 1'b1;
         f_next = s_w - dy_w18;
      end else begin
         k_w    = {1'b0, q_ff};
         f_next = s_w;
      end
   end
   assign k_x    = $signed({{(X_W - K_W){1'b0}}, k_w});
   assign x_next = step_pos_ff ? (x_ff + k_x) : (step_neg_ff ? (x_ff - k_x) : x_ff);

   // x position after the jump over rows above the tile
   assign jump_x = $signed({{(X_W - GAIN_W){1'b0}}, div_quo[GAIN_W-1:0]});

   // crossing x clamped to the tile
   assign cols_x = $signed({{(X_W - COL_W){1'b0}}, tile_cols});
   always_comb begin
      if (x_ff[X_W-1])        cx = '0;
      else if (x_ff > cols_x) cx = tile_cols;
      else                    cx = x_ff[COL_W-1:0];
   end

   // shared divider
   assign div_dividend = cmd.div_gain ? {{(PROD_W - GAIN_W){1'b0}}, gain_ff} : prod_ff;

   pesw_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (dy_ff),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // register updates
   always_comb begin
      top_x_in       = top_x_ff;
      top_y_in       = top_y_ff;
      bot_x_in       = bot_x_ff;
      bot_y_in       = bot_y_ff;
      row_in         = row_ff;
      count_in       = count_ff;
      dy_in          = dy_ff;
      gain_in        = gain_ff;
      neg_top_in     = neg_top_ff;
      step_pos_in    = step_pos_ff;
      step_neg_in    = step_neg_ff;
      prod_in        = prod_ff;
      x_in           = x_ff;
      f_in           = f_ff;
      q_in           = q_ff;
      r_in           = r_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_row_in     = rsp_row_ff;
      rsp_cross_x_in = rsp_cross_x_ff;
      rsp_last_in    = rsp_last_ff;
      // order endpoints so the edge runs downward
      if (cmd.load) begin
         if (req_end_y < req_start_y) begin
            top_x_in = req_end_x;
            top_y_in = req_end_y;
            bot_x_in = req_start_x;
            bot_y_in = req_start_y;
         end else begin
            top_x_in = req_start_x;
            top_y_in = req_start_y;
            bot_x_in = req_end_x;
            bot_y_in = req_end_y;
         end
      end
      if (cmd.setup) begin
         row_in      = y0;
         count_in    = lo - {1'b0, y0};
         dy_in       = dy_s[DY_W-1:0];
         gain_in     = dx_mag[GAIN_W-1:0] + 1'b1;
         neg_top_in  = ~top_y_ff + 1'b1;
         step_pos_in = !dx_s[COORD_W] && (dx_s != '0);
         step_neg_in = dx_s[COORD_W];
         x_in        = {{(X_W - COORD_W){top_x_ff[COORD_W-1]}}, top_x_ff};
         f_in        = -$signed(F_W'(1));
      end
      if (cmd.mul) begin
         prod_in = {{(PROD_W - GAIN_W){1'b0}}, gain_ff} *
                   {{(PROD_W - COORD_W){1'b0}}, neg_top_ff};
      end
      if (cmd.take_jump) begin
         x_in = step_pos_ff ? (x_ff + jump_x) : (step_neg_ff ? (x_ff - jump_x) : x_ff);
         f_in = $signed({1'b0, div_rem}) - $signed(F_W'(1));
      end
      if (cmd.take_gain) begin
         q_in = div_quo[GAIN_W-1:0];
         r_in = div_rem;
      end
      // hand the crossing over and advance one row
      if (cmd.emit) begin
         rsp_valid_in   = 1'b1;
         rsp_row_in     = row_ff;
         rsp_cross_x_in = cx;
         rsp_last_in    = (count_ff == CNT_W'(1));
         row_in         = row_ff + 1'b1;
         count_in       = count_ff - 1'b1;
         x_in           = x_next;
         f_in           = f_next[F_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      top_x_ff       <= top_x_in;
      top_y_ff       <= top_y_in;
      bot_x_ff       <= bot_x_in;
      bot_y_ff       <= bot_y_in;
      row_ff         <= row_in;
      count_ff       <= count_in;
      dy_ff          <= dy_in;
      gain_ff        <= gain_in;
      neg_top_ff     <= neg_top_in;
      step_pos_ff    <= step_pos_in;
      step_neg_ff    <= step_neg_in;
      prod_ff        <= prod_in;
      x_ff           <= x_in;
      f_ff           <= f_in;
      q_ff           <= q_in;
      r_ff           <= r_in;
      rsp_row_ff     <= rsp_row_in;
      rsp_cross_x_ff <= rsp_cross_x_in;
      rsp_last_ff    <= rsp_last_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // status
   assign st.reject   = reject;
   assign st.neg_top  = top_y_ff[COORD_W-1];
   assign st.div_done = div_done;
   assign st.out_free = !rsp_valid_ff || rsp_ready;
   assign st.last_row = (count_ff == CNT_W'(1));

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_row     = rsp_row_ff;
   assign rsp_cross_x = rsp_cross_x_ff;
   assign rsp_last    = rsp_last_ff;

`ifndef SYNTHESIS
   // every emitted row lies inside the tile
   a_row_in_tile: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> ({1'b0, row_ff} < limit))
      else $error("crossing row outside the tile");

   // the error accumulator stays normalised while walking
   a_err_range: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (f_ff >= -$signed(F_W'(1))) &&
                   ($signed({f_ff[F_W-1], f_ff}) < $signed({2'b00, dy_ff})))
      else $error("error accumulator out of range");

   // a new edge is never taken while a division is running
   a_load_div_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !div_busy)
      else $error("edge loaded during division");
`endif

endmodule
`default_nettype wire

>>> hdl/polygon_edge_scanline_walker.sv
// polygon_edge_scanline_walker: top level holding the tile registers and
// joining the controller and datapath. Depends on pesw_pkg, pesw_ctrl and
// pesw_datapath.
//
// Walks one polygon edge down the rows of a tile and gives one crossing
// (row, clamped x, last flag) per tile row the edge covers; horizontal
// edges and edges outside the tile give nothing. One edge is handled at a
// time: after the transfer in, a setup state, then, only for an edge that
// starts above the tile, a multiply state and a pass of the shared
// one-bit-a-cycle divider for the row jump, then another divider pass to
// split the per-row x step, then one crossing per cycle while the result
// register is free. The result register lets the next edge be taken while
// the final crossing still waits. tile_rows and tile_cols are written
// through the csr port (index 0 and 1, other indexes ignored); the user
// must write them only while the block is idle, which the block itself
// does not enforce.
`default_nettype none
module polygon_edge_scanline_walker
   import pesw_pkg::*;
#(
   parameter int MAX_ROWS = 64
)
(
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_ready,
   input  wire signed [COORD_W-1:0]  req_start_x,
   input  wire signed [COORD_W-1:0]  req_start_y,
   input  wire signed [COORD_W-1:0]  req_end_x,
   input  wire signed [COORD_W-1:0]  req_end_y,
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   output logic [ROW_W-1:0]          rsp_row,
   output logic [COL_W-1:0]          rsp_cross_x,
   output logic                      rsp_last,
   input  wire                       csr_valid,
   output logic                      csr_ready,
   input  wire [CSR_IDX_W-1:0]       csr_index,
   input  wire [CSR_DATA_W-1:0]      csr_wdata
);

   logic [ROWS_W-1:0] tile_rows_ff, tile_rows_in;
   logic [COL_W-1:0]  tile_cols_ff, tile_cols_in;
   cmd_type           cmd;
   status_type        st;

   // tile registers, always ready for a transfer
   assign csr_ready = 1'b1;
   always_comb begin
      tile_rows_in = tile_rows_ff;
      tile_cols_in = tile_cols_ff;
      if (csr_valid) begin
         if (csr_index == REG_TILE_ROWS) tile_rows_in = csr_wdata[ROWS_W-1:0];
         if (csr_index == REG_TILE_COLS) tile_cols_in = csr_wdata[COL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_rows_ff <= TILE_ROWS_RST;
         tile_cols_ff <= TILE_COLS_RST;
      end else begin
         tile_rows_ff <= tile_rows_in;
         tile_cols_ff <= tile_cols_in;
      end
   end

   // sequencer
   pesw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   // edge arithmetic and result register
   pesw_datapath #(
      .MAX_ROWS (MAX_ROWS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .st          (st),
      .tile_rows   (tile_rows_ff),
      .tile_cols   (tile_cols_ff),
      .req_start_x (req_start_x),
      .req_start_y (req_start_y),
      .req_end_x   (req_end_x),
      .req_end_y   (req_end_y),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_row     (rsp_row),
      .rsp_cross_x (rsp_cross_x),
      .rsp_last    (rsp_last)
   );

endmodule
`default_nettype wire
